// ----- src/lcgj_pkg.sv -----
// Package for the LCG jump-ahead block: generator constants, pipeline word
// type and the per-stage squared-map constants. No dependencies.
package lcgj_pkg;

  localparam logic [31:0] LCG_MUL = 32'h0003_43FD;
  localparam logic [31:0] LCG_INC = 32'h0026_9EC3;
  localparam int          WORD_W  = 32;

  // Word carried down the pipeline: the input word plus the composed map
  // x -> acc_mul*x + acc_add built from the count bits seen so far.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] state;
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] acc_mul;
    logic [WORD_W-1:0] acc_add;
  } stage_t;

  // Multiplier of the map for 2^idx generator steps.
  function automatic logic [WORD_W-1:0] pow_mul(input int idx);
    logic [WORD_W-1:0] m;
    m = LCG_MUL;
    for (int j = 0; j < idx; j++) begin
      m = m * m;
    end
    return m;
  endfunction

  // Increment of the map for 2^idx generator steps.
  function automatic logic [WORD_W-1:0] pow_add(input int idx);
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] c;
    m = LCG_MUL;
    c = LCG_INC;
    for (int j = 0; j < idx; j++) begin
      c = (m + 32'd1) * c;
      m = m * m;
    end
    return c;
  endfunction

endpackage

// ----- src/lcgj_stage.sv -----
// One square-and-multiply stage: folds the map for one count bit into the
// accumulated map when that bit is set. Depends on lcgj_pkg.
module lcgj_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  lcgj_pkg::stage_t d,
  input  logic            use_bit,
  input  logic [31:0]     k_mul,
  input  logic [31:0]     k_add,
  output lcgj_pkg::stage_t q_r
);
  import lcgj_pkg::*;

  stage_t q_nxt;

  always_comb begin
    q_nxt = d;
    if (use_bit) begin
      // two independent 32x32 low-half products, one add behind the second
      q_nxt.acc_mul = d.acc_mul * k_mul;
      q_nxt.acc_add = d.acc_add * k_mul + k_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= q_nxt.valid;
    end
    q_r.state   <= q_nxt.state;
    q_r.count   <= q_nxt.count;
    q_r.acc_mul <= q_nxt.acc_mul;
    q_r.acc_add <= q_nxt.acc_add;
  end

endmodule

// ----- src/lcgj_apply.sv -----
// Output stage: applies the composed map to the start state and registers
// the result word with its strobe. Depends on lcgj_pkg.
module lcgj_apply (
  input  logic             clk,
  input  logic             rst_n,
  input  lcgj_pkg::stage_t d,
  output logic             valid_r,
  output logic [31:0]      state_r
);
  import lcgj_pkg::*;

  logic [WORD_W-1:0] state_nxt;

  assign state_nxt = d.acc_mul * d.state + d.acc_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= d.valid;
    end
    state_r <= state_nxt;
  end

endmodule

// ----- src/lcg_jump_ahead.sv -----
// Jump-ahead for the LCG x' = 214013*x + 2531011 mod 2^32.
// Top level; depends on lcgj_pkg, lcgj_stage and lcgj_apply.
//
// Use: drive in_start_state and in_step_count and raise start; the word is
// taken at a rising edge where start is high and busy is low. Only the low
// COUNT_BITS bits of in_step_count count; a count of zero returns the state
// unchanged.
// Result: out_jumped_state is shown for exactly one cycle with out_valid
// high, once the word has passed the stage registers and the output
// register; it is taken at the edge that ends that cycle.
// Throughput: one word per cycle while busy is low. The pipeline has one
// register stage per count bit (two 32x32 low-half multiplies side by side
// each) and a final stage that does the multiply and add onto the start
// state. Reset (rst_n low, synchronous) clears all valid bits, so words
// in flight are dropped, and holds busy high; busy falls in the cycle after
// reset ends and stays low. The receiver cannot stall, so nothing ever
// backs up.
module lcg_jump_ahead #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_start_state,
  input  logic [31:0] in_step_count,
  output logic        out_valid,
  output logic [31:0] out_jumped_state
);
  import lcgj_pkg::*;

  localparam int LAT = COUNT_BITS + 1;

  logic   busy_r;
  stage_t pipe [0:COUNT_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  assign pipe[0] = '{valid:   start && !busy_r,
                     state:   in_start_state,
                     count:   in_step_count,
                     acc_mul: 32'd1,
                     acc_add: 32'd0};

  for (genvar i = 0; i < COUNT_BITS; i++) begin : g_stage
    localparam logic [31:0] K_MUL = pow_mul(i);
    localparam logic [31:0] K_ADD = pow_add(i);

    lcgj_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .d       (pipe[i]),
      .use_bit (pipe[i].count[i]),
      .k_mul   (K_MUL),
      .k_add   (K_ADD),
      .q_r     (pipe[i+1])
    );
  end

  lcgj_apply u_apply (
    .clk     (clk),
    .rst_n   (rst_n),
    .d       (pipe[COUNT_BITS]),
    .valid_r (out_valid),
    .state_r (out_jumped_state)
  );

`ifndef NO_ASSERTIONS
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high after reset");

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LAT) out_valid)
    else $error("accepted word gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted word");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_step_count[COUNT_BITS-1:0] == '0) |-> ##(LAT)
      (out_jumped_state == $past(in_start_state, LAT)))
    else $error("zero count changed the state");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_step_count[COUNT_BITS-1:0] == COUNT_BITS'(1)) |-> ##(LAT)
      (out_jumped_state == 32'($past(in_start_state, LAT) * LCG_MUL + LCG_INC)))
    else $error("single step wrong");
`endif

endmodule
